// ===== design/ffmt_pkg.sv =====
`default_nettype none

package ffmt_pkg;

	localparam int LEAVES_DEFAULT      = 1024;
	localparam int AMOUNT_BITS_DEFAULT = 32;

	localparam logic REQ_SET   = 1'b0;
	localparam logic REQ_ALLOC = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [9:0]  slot_index;
		logic [31:0] amount;
	} req_t;

	typedef struct packed {
		logic        granted;
		logic [10:0] slot_number;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ROOT,
		ST_CHECK,
		ST_DESC,
		ST_LEAF,
		ST_UPD,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

// ===== design/first_fit_max_tree_allocator.sv =====
`default_nettype none

// First-fit allocator over a max segment tree of LEAVES slots, held in one
// synchronous memory of 2*SPAN entries (SPAN = LEAVES rounded up to a power
// of two, LEVELS = log2(SPAN)) with one read and one write port. After reset
// the block clears every memory entry, one entry a cycle, before it takes
// its first transaction. Each transaction gives one response. A grant goes
// through ST_ROOT, ST_CHECK, ST_DESC, ST_LEAF, ST_UPD and ST_FIN, a request
// that does not fit goes from ST_CHECK to ST_FIN, a set goes through ST_UPD
// to ST_FIN, and a set outside the slots goes straight to ST_FIN. ST_FIN
// waits while the previous response still waits for rsp_ready. Through the
// memory port, the descent reads one left child per level and the rebuild
// reads one sibling per level while it writes the parent. The next
// transaction can be accepted in the cycle after the response is loaded,
// even while that response waits.
module first_fit_max_tree_allocator #(
	parameter int LEAVES      = ffmt_pkg::LEAVES_DEFAULT,
	parameter int AMOUNT_BITS = ffmt_pkg::AMOUNT_BITS_DEFAULT
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire ffmt_pkg::req_t req_data,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output ffmt_pkg::rsp_t     rsp_data
);

	localparam int LEVELS = $clog2(LEAVES);
	localparam int SPAN   = 1 << LEVELS;
	localparam int NODE_W = LEVELS + 1;
	localparam int DEPTH  = 2 * SPAN;

	ffmt_pkg::state_t state_q, state_d;

	logic [AMOUNT_BITS-1:0] mem [DEPTH];
	logic [AMOUNT_BITS-1:0] rdata_q;

	logic [NODE_W-1:0]      clr_q;
	logic [NODE_W-1:0]      node_q;
	logic [AMOUNT_BITS-1:0] amt_q;
	logic [AMOUNT_BITS-1:0] cur_q;
	logic                   granted_q;
	logic [10:0]            slot_q;
	logic                   rsp_valid_q;
	ffmt_pkg::rsp_t         rsp_data_q;

	logic                   rd_en;
	logic [NODE_W-1:0]      rd_addr;
	logic                   wr_en;
	logic [NODE_W-1:0]      wr_addr;
	logic [AMOUNT_BITS-1:0] wr_data;

	logic [AMOUNT_BITS-1:0] in_amt;
	logic                   in_range;
	logic [NODE_W-1:0]      in_leaf;
	logic [NODE_W-1:0]      in_sib;
	logic                   accept;
	logic                   fits;
	logic                   go_left;
	logic [NODE_W-1:0]      nxt;
	logic                   nxt_leaf;
	logic [NODE_W-1:0]      parent;
	logic                   parent_root;
	logic [AMOUNT_BITS-1:0] leaf_new;
	logic [AMOUNT_BITS-1:0] parent_val;
	logic [NODE_W-1:0]      slot_ofs;
	logic                   rsp_free;

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == ffmt_pkg::ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;
	assign rsp_free  = !rsp_valid_q || rsp_ready;

	assign in_amt   = AMOUNT_BITS'({32'b0, req_data.amount});
	assign in_range = {7'b0, req_data.slot_index} < 17'(LEAVES);
	assign in_leaf  = (NODE_W'(1) << LEVELS) | NODE_W'({{NODE_W{1'b0}}, req_data.slot_index});
	assign in_sib   = {in_leaf[NODE_W-1:1], ~in_leaf[0]};

	assign fits        = rdata_q >= amt_q;
	assign go_left     = rdata_q >= amt_q;
	assign nxt         = {node_q[NODE_W-2:0], ~go_left};
	assign nxt_leaf    = nxt[NODE_W-1];
	assign parent      = node_q >> 1;
	assign parent_root = (parent == NODE_W'(1));
	assign leaf_new    = rdata_q - amt_q;
	assign parent_val  = (cur_q >= rdata_q) ? cur_q : rdata_q;
	assign slot_ofs    = {1'b0, node_q[NODE_W-2:0]} + NODE_W'(1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ffmt_pkg::ST_CLEAR: begin
				if (&clr_q) state_d = ffmt_pkg::ST_IDLE;
			end
			ffmt_pkg::ST_IDLE: begin
				if (accept) begin
					if (req_data.req_type == ffmt_pkg::REQ_ALLOC) state_d = ffmt_pkg::ST_ROOT;
					else if (in_range) state_d = ffmt_pkg::ST_UPD;
					else state_d = ffmt_pkg::ST_FIN;
				end
			end
			ffmt_pkg::ST_ROOT:  state_d = ffmt_pkg::ST_CHECK;
			ffmt_pkg::ST_CHECK: state_d = fits ? ffmt_pkg::ST_DESC : ffmt_pkg::ST_FIN;
			ffmt_pkg::ST_DESC: begin
				if (nxt_leaf) state_d = ffmt_pkg::ST_LEAF;
			end
			ffmt_pkg::ST_LEAF:  state_d = ffmt_pkg::ST_UPD;
			ffmt_pkg::ST_UPD: begin
				if (parent_root) state_d = ffmt_pkg::ST_FIN;
			end
			ffmt_pkg::ST_FIN: begin
				if (rsp_free) state_d = ffmt_pkg::ST_IDLE;
			end
			default: state_d = ffmt_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		case (state_q)
			ffmt_pkg::ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
			end
			ffmt_pkg::ST_IDLE: begin
				if (accept && req_data.req_type == ffmt_pkg::REQ_SET && in_range) begin
					wr_en   = 1'b1;
					wr_addr = in_leaf;
					wr_data = in_amt;
					rd_en   = 1'b1;
					rd_addr = in_sib;
				end
			end
			ffmt_pkg::ST_ROOT: begin
				rd_en   = 1'b1;
				rd_addr = NODE_W'(1);
			end
			ffmt_pkg::ST_CHECK: begin
				rd_en   = fits;
				rd_addr = NODE_W'(2);
			end
			ffmt_pkg::ST_DESC: begin
				rd_en   = 1'b1;
				rd_addr = nxt_leaf ? nxt : {nxt[NODE_W-2:0], 1'b0};
			end
			ffmt_pkg::ST_LEAF: begin
				wr_en   = 1'b1;
				wr_addr = node_q;
				wr_data = leaf_new;
				rd_en   = 1'b1;
				rd_addr = {node_q[NODE_W-1:1], ~node_q[0]};
			end
			ffmt_pkg::ST_UPD: begin
				wr_en   = 1'b1;
				wr_addr = parent;
				wr_data = parent_val;
				rd_en   = !parent_root;
				rd_addr = {parent[NODE_W-1:1], ~parent[0]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ffmt_pkg::ST_IDLE: begin
				if (accept) begin
					amt_q     <= in_amt;
					cur_q     <= in_amt;
					node_q    <= in_leaf;
					granted_q <= 1'b0;
					slot_q    <= '0;
				end
			end
			ffmt_pkg::ST_CHECK: node_q <= NODE_W'(1);
			ffmt_pkg::ST_DESC: begin
				node_q <= nxt;
			end
			ffmt_pkg::ST_LEAF: begin
				cur_q     <= leaf_new;
				granted_q <= 1'b1;
				slot_q    <= 11'({11'b0, slot_ofs});
			end
			ffmt_pkg::ST_UPD: begin
				cur_q  <= parent_val;
				node_q <= parent;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffmt_pkg::ST_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ffmt_pkg::ST_CLEAR) clr_q <= clr_q + NODE_W'(1);
			if (state_q == ffmt_pkg::ST_FIN && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ffmt_pkg::ST_FIN && rsp_free) begin
			rsp_data_q.granted     <= granted_q;
			rsp_data_q.slot_number <= slot_q;
		end
	end

	a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("read and write hit the same tree entry");

	a_desc_not_leaf: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffmt_pkg::ST_DESC) |-> !node_q[NODE_W-1])
		else $error("descent passed the leaf level");

	a_leaf_is_leaf: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffmt_pkg::ST_LEAF) |-> node_q[NODE_W-1])
		else $error("leaf update on an inner node");

	a_upd_below_root: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffmt_pkg::ST_UPD) |-> (node_q != NODE_W'(1)))
		else $error("rebuild climbed above the root");

	a_fin_loads_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffmt_pkg::ST_FIN && rsp_free) |=> (rsp_valid && state_q == ffmt_pkg::ST_IDLE))
		else $error("finished transaction did not reach the response register");

endmodule

`default_nettype wire
